/* sv/sfa_pkg.sv */
// ----------------------------------------------------------------------------
// sfa_pkg: shared definitions for the segment fit allocator
// Command and status codes, micro-operation codes passed from the controller
// to the datapath, and the status bundle returned by the datapath.
// ----------------------------------------------------------------------------
package sfa_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;

  // Hole choice policies.
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_MEMSIZE = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_COMPACT  = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Reset value of the managed memory size.
  localparam int unsigned MEM_SIZE_RESET = 4096;

  // Micro-operations issued by the controller.
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE   = 4'd0;
  localparam op_t OP_INIT   = 4'd1;
  localparam op_t OP_ACCEPT = 4'd2;
  localparam op_t OP_CSCAN  = 4'd3;
  localparam op_t OP_CDEC   = 4'd4;
  localparam op_t OP_SHUP   = 4'd5;
  localparam op_t OP_CHOLE  = 4'd6;
  localparam op_t OP_CSEG   = 4'd7;
  localparam op_t OP_DSCAN  = 4'd8;
  localparam op_t OP_DMERGE = 4'd9;
  localparam op_t OP_SHDN   = 4'd10;
  localparam op_t OP_KSCAN  = 4'd11;
  localparam op_t OP_KTAIL  = 4'd12;
  localparam op_t OP_PUB    = 4'd13;

  // Status returned by the datapath.
  typedef struct packed {
    logic sweep_done;
    logic need_split;
    logic del_shift;
    logic out_free;
  } sts_t;

endpackage

/* sv/segment_fit_allocator.sv */
// ----------------------------------------------------------------------------
// segment_fit_allocator: variable partition allocator
// First, best or worst fit placement of segments in an offset-ordered
// region table, with delete-and-merge and full compaction.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   cmd_i, seg_id_i, req_size_i
//   out       output     out_valid_o / out_stall_i status_o, base_o
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One command at a time. A create sweeps the table (N regions), and a split
// then shifts the tail up. A delete sweeps up to the match and shifts the
// tail down; a compact sweeps all N once. Every sweep reads through the
// single table memory read port. After reset the table sets up its first
// hole before any command is taken.
// The result beat is held while out_stall_i is high; no new command is
// taken until it has been handed to the result register.
// ----------------------------------------------------------------------------
module segment_fit_allocator import sfa_pkg::*; #(
  parameter int MAX_REGIONS = 64,
  parameter int ADDR_BITS   = 20,
  parameter int ID_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] seg_id_i,
  input  logic [20:0] req_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [19:0] base_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [20:0] cfg_data_i
);

  op_t  op;
  sts_t sts;

  // Sequencer.
  sfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .op_o       (op),
    .in_stall_o (in_stall_o)
  );

  // Table and arithmetic.
  sfa_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .ADDR_BITS   (ADDR_BITS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .sts_o       (sts),
    .seg_id_i    (seg_id_i),
    .req_size_i  (req_size_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .base_o      (base_o)
  );

endmodule

/* sv/sfa_ctrl.sv */
// ----------------------------------------------------------------------------
// sfa_ctrl: command sequencer
// Walks each command through its table sweeps and decision steps and tells
// the datapath which micro-operation to perform in each cycle.
// ----------------------------------------------------------------------------
module sfa_ctrl import sfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  input  sts_t       sts_i,
  output op_t        op_o,
  output logic       in_stall_o
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CSCAN  = 4'd2;
  localparam logic [3:0] S_CDEC   = 4'd3;
  localparam logic [3:0] S_SHUP   = 4'd4;
  localparam logic [3:0] S_CHOLE  = 4'd5;
  localparam logic [3:0] S_CSEG   = 4'd6;
  localparam logic [3:0] S_DSCAN  = 4'd7;
  localparam logic [3:0] S_DMERGE = 4'd8;
  localparam logic [3:0] S_SHDN   = 4'd9;
  localparam logic [3:0] S_KSCAN  = 4'd10;
  localparam logic [3:0] S_KTAIL  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and micro-operation.
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_INIT: begin
        op_o    = OP_INIT;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_ACCEPT;
          case (cmd_i)
            CMD_CREATE:  state_d = S_CSCAN;
            CMD_DELETE:  state_d = S_DSCAN;
            CMD_COMPACT: state_d = S_KSCAN;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_CSCAN: begin
        op_o = OP_CSCAN;
        if (sts_i.sweep_done) state_d = S_CDEC;
      end
      S_CDEC: begin
        op_o    = OP_CDEC;
        state_d = sts_i.need_split ? S_SHUP : S_DONE;
      end
      S_SHUP: begin
        op_o = OP_SHUP;
        if (sts_i.sweep_done) state_d = S_CHOLE;
      end
      S_CHOLE: begin
        op_o    = OP_CHOLE;
        state_d = S_CSEG;
      end
      S_CSEG: begin
        op_o    = OP_CSEG;
        state_d = S_DONE;
      end
      S_DSCAN: begin
        op_o = OP_DSCAN;
        if (sts_i.sweep_done) state_d = S_DMERGE;
      end
      S_DMERGE: begin
        op_o    = OP_DMERGE;
        state_d = sts_i.del_shift ? S_SHDN : S_DONE;
      end
      S_SHDN: begin
        op_o = OP_SHDN;
        if (sts_i.sweep_done) state_d = S_DONE;
      end
      S_KSCAN: begin
        op_o = OP_KSCAN;
        if (sts_i.sweep_done) state_d = S_KTAIL;
      end
      S_KTAIL: begin
        op_o    = OP_KTAIL;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          op_o    = OP_PUB;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/sfa_dp.sv */
// ----------------------------------------------------------------------------
// sfa_dp: region table datapath
// Holds the region table in a single-port-write memory with a registered
// read, the sweep pointers, the fit search registers and the result beat.
// ----------------------------------------------------------------------------
module sfa_dp import sfa_pkg::*; #(
  parameter int MAX_REGIONS = 64,
  parameter int ADDR_BITS   = 20,
  parameter int ID_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  op_t         op_i,
  output sts_t        sts_o,
  input  logic [15:0] seg_id_i,
  input  logic [20:0] req_size_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [20:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [19:0] base_o
);

  localparam int IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNTW = $clog2(MAX_REGIONS + 1);
  localparam int LW   = ADDR_BITS + 1;
  localparam int CW   = (LW > 21) ? LW : 21;
  localparam int EW   = 1 + ID_BITS + ADDR_BITS + LW;
  localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_REGIONS);
  localparam longint unsigned CAP = longint'(1) << ADDR_BITS;
  localparam longint unsigned MSR = (MEM_SIZE_RESET > CAP) ? CAP : MEM_SIZE_RESET;

  // Region table.
  logic [EW-1:0] mem [MAX_REGIONS];
  logic [EW-1:0] rdata_q;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  // Fields of the entry that was read last cycle.
  logic                 e_free;
  logic [ID_BITS-1:0]   e_owner;
  logic [ADDR_BITS-1:0] e_base;
  logic [LW-1:0]        e_len;
  logic [CW-1:0]        e_lenc;
  assign {e_free, e_owner, e_base, e_len} = rdata_q;
  assign e_lenc = CW'(e_len);

  // Registers.
  logic                 rvld_q, rvld_d;
  logic [IW-1:0]        ridx_q;
  logic [CNTW-1:0]      count_q, count_d, idx_q, idx_d, w_q, w_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [CW-1:0]        size_q, size_d;
  logic                 found_q, found_d;
  logic [IW-1:0]        pick_q, pick_d;
  logic [ADDR_BITS-1:0] pick_base_q, pick_base_d;
  logic [LW-1:0]        pick_len_q, pick_len_d;
  logic [LW-1:0]        total_q, total_d;
  logic                 prv_free_q, prv_free_d, nxt_free_q, nxt_free_d;
  logic [LW-1:0]        prv_len_q, prv_len_d, nxt_len_q, nxt_len_d;
  logic [ADDR_BITS-1:0] prv_base_q, prv_base_d;
  logic [1:0]           k_q, k_d;
  logic [LW-1:0]        pos_q, pos_d;
  logic [2:0]           res_st_q, res_st_d, ost_q, ost_d;
  logic [ADDR_BITS-1:0] res_base_q, res_base_d, obase_q, obase_d;
  logic                 ov_q, ov_d;
  logic [LW-1:0]        msize_q, msize_d;
  logic [1:0]           pol_q, pol_d;

  // Input conversions and the clamped memory size.
  logic [63:0] id64, base64;
  logic [33:0] v34, clamp34;
  assign id64    = 64'(seg_id_i);
  assign v34     = 34'(cfg_data_i);
  assign clamp34 = (v34 == 34'd0) ? 34'd1 : ((v34 > 34'(CAP)) ? 34'(CAP) : v34);
  assign base64  = 64'(obase_q);

  // Read side of each sweep.
  logic [CNTW-1:0] idx_m1;
  assign idx_m1 = idx_q - CNTW'(1);
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q[IW-1:0];
    case (op_i)
      OP_CSCAN, OP_KSCAN, OP_SHDN: rd_en = (idx_q < count_q);
      OP_DSCAN: rd_en = (idx_q < count_q) && !found_q;
      OP_SHUP: begin
        rd_en   = (idx_q > (CNTW'(pick_q) + CNTW'(1)));
        rd_addr = idx_m1[IW-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end

  logic sweep_done;
  assign sweep_done = !rd_en && !rvld_q;

  // Fit test of the entry just read.
  logic fits, better;
  assign fits   = e_free && (e_lenc >= size_q);
  assign better = !found_q
               || (pol_q == POL_BEST  && e_len < pick_len_q)
               || (pol_q == POL_WORST && e_len > pick_len_q);

  assign sts_o.sweep_done = sweep_done;
  assign sts_o.need_split = (size_q != '0) && found_q && (CW'(pick_len_q) != size_q)
                          && (count_q != MAXC);
  assign sts_o.del_shift  = found_q && (prv_free_q || nxt_free_q);
  assign sts_o.out_free   = !ov_q || !out_stall_i;

  // Micro-operation execution.
  logic [IW-1:0]   p_addr;
  logic [LW-1:0]   merged;
  logic [CNTW-1:0] shdn_start;
  always_comb begin
    rvld_d      = rd_en;
    count_d     = count_q;
    idx_d       = rd_en ? ((op_i == OP_SHUP) ? idx_m1 : idx_q + CNTW'(1)) : idx_q;
    w_d         = w_q;
    id_d        = id_q;
    size_d      = size_q;
    found_d     = found_q;
    pick_d      = pick_q;
    pick_base_d = pick_base_q;
    pick_len_d  = pick_len_q;
    total_d     = total_q;
    prv_free_d  = prv_free_q;
    prv_len_d   = prv_len_q;
    prv_base_d  = prv_base_q;
    nxt_free_d  = nxt_free_q;
    nxt_len_d   = nxt_len_q;
    k_d         = k_q;
    pos_d       = pos_q;
    res_st_d    = res_st_q;
    res_base_d  = res_base_q;
    ov_d        = ov_q;
    ost_d       = ost_q;
    obase_d     = obase_q;
    msize_d     = msize_q;
    pol_d       = pol_q;
    wr_en       = 1'b0;
    wr_addr     = ridx_q;
    wr_data     = rdata_q;
    p_addr      = prv_free_q ? (pick_q - IW'(1)) : pick_q;
    merged      = (prv_free_q ? prv_len_q : '0) + pick_len_q + (nxt_free_q ? nxt_len_q : '0);
    shdn_start  = CNTW'(pick_q) + CNTW'(1) + CNTW'(nxt_free_q);

    // The result beat leaves when taken.
    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (op_i)
      OP_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {1'b1, ID_BITS'(0), ADDR_BITS'(0), msize_q};
        count_d = CNTW'(1);
      end
      OP_ACCEPT: begin
        id_d       = id64[ID_BITS-1:0];
        size_d     = CW'(req_size_i);
        idx_d      = '0;
        found_d    = 1'b0;
        total_d    = '0;
        prv_free_d = 1'b0;
        nxt_free_d = 1'b0;
        pos_d      = '0;
        w_d        = '0;
        res_st_d   = ST_OK;
        res_base_d = '0;
      end
      OP_CSCAN: begin
        if (rvld_q && e_free) begin
          total_d = total_q + e_len;
          if (fits && better) begin
            found_d     = 1'b1;
            pick_d      = ridx_q;
            pick_base_d = e_base;
            pick_len_d  = e_len;
          end
        end
      end
      OP_CDEC: begin
        if (size_q == '0) begin
          res_st_d = ST_OK;
        end else if (!found_q) begin
          res_st_d = (CW'(total_q) >= size_q) ? ST_COMPACT : ST_NOSPACE;
        end else if (CW'(pick_len_q) == size_q) begin
          // Exact fit: the hole becomes the segment.
          wr_en      = 1'b1;
          wr_addr    = pick_q;
          wr_data    = {1'b0, id_q, pick_base_q, pick_len_q};
          res_base_d = pick_base_q;
        end else if (count_q == MAXC) begin
          res_st_d = ST_FULL;
        end else begin
          idx_d      = count_q;
          res_base_d = pick_base_q;
        end
      end
      OP_SHUP: begin
        if (rvld_q) begin
          wr_en   = 1'b1;
          wr_addr = ridx_q + IW'(1);
        end
      end
      OP_CHOLE: begin
        wr_en   = 1'b1;
        wr_addr = pick_q + IW'(1);
        wr_data = {1'b1, ID_BITS'(0), pick_base_q + size_q[ADDR_BITS-1:0],
                   pick_len_q - size_q[LW-1:0]};
      end
      OP_CSEG: begin
        wr_en   = 1'b1;
        wr_addr = pick_q;
        wr_data = {1'b0, id_q, pick_base_q, size_q[LW-1:0]};
        count_d = count_q + CNTW'(1);
      end
      OP_DSCAN: begin
        if (rvld_q) begin
          if (!found_q) begin
            if (!e_free && e_owner == id_q) begin
              found_d     = 1'b1;
              pick_d      = ridx_q;
              pick_base_d = e_base;
              pick_len_d  = e_len;
            end else begin
              prv_free_d = e_free;
              prv_len_d  = e_len;
              prv_base_d = e_base;
            end
          end else begin
            nxt_free_d = e_free;
            nxt_len_d  = e_len;
          end
        end
      end
      OP_DMERGE: begin
        if (!found_q) begin
          res_st_d = ST_NOTFOUND;
        end else begin
          // Freed region absorbs any neighbouring holes.
          wr_en   = 1'b1;
          wr_addr = p_addr;
          wr_data = {1'b1, ID_BITS'(0), prv_free_q ? prv_base_q : pick_base_q, merged};
          k_d     = 2'(prv_free_q) + 2'(nxt_free_q);
          idx_d   = shdn_start;
        end
      end
      OP_SHDN: begin
        if (rvld_q) begin
          wr_en   = 1'b1;
          wr_addr = ridx_q - IW'(k_q);
        end
        if (sweep_done) count_d = count_q - CNTW'(k_q);
      end
      OP_KSCAN: begin
        if (rvld_q && !e_free) begin
          wr_en   = 1'b1;
          wr_addr = w_q[IW-1:0];
          wr_data = {1'b0, e_owner, pos_q[ADDR_BITS-1:0], e_len};
          pos_d   = pos_q + e_len;
          w_d     = w_q + CNTW'(1);
        end
      end
      OP_KTAIL: begin
        if (pos_q < msize_q && w_q < MAXC) begin
          wr_en   = 1'b1;
          wr_addr = w_q[IW-1:0];
          wr_data = {1'b1, ID_BITS'(0), pos_q[ADDR_BITS-1:0], msize_q - pos_q};
          count_d = w_q + CNTW'(1);
        end else begin
          count_d = w_q;
        end
      end
      OP_PUB: begin
        ov_d    = 1'b1;
        ost_d   = res_st_q;
        obase_d = res_base_q;
      end
      default: ;
    endcase

    // Configuration writes; a new size restarts the table as one hole.
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_POLICY) begin
        pol_d = cfg_data_i[1:0];
      end else if (cfg_idx_i == CFG_MEMSIZE) begin
        msize_d = clamp34[LW-1:0];
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {1'b1, ID_BITS'(0), ADDR_BITS'(0), clamp34[LW-1:0]};
        count_d = CNTW'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q  <= 1'b0;
      count_q <= CNTW'(1);
      ov_q    <= 1'b0;
      msize_q <= LW'(MSR);
      pol_q   <= '0;
      found_q <= 1'b0;
    end else begin
      rvld_q  <= rvld_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      msize_q <= msize_d;
      pol_q   <= pol_d;
      found_q <= found_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ridx_q      <= rd_addr;
    idx_q       <= idx_d;
    w_q         <= w_d;
    id_q        <= id_d;
    size_q      <= size_d;
    pick_q      <= pick_d;
    pick_base_q <= pick_base_d;
    pick_len_q  <= pick_len_d;
    total_q     <= total_d;
    prv_free_q  <= prv_free_d;
    prv_len_q   <= prv_len_d;
    prv_base_q  <= prv_base_d;
    nxt_free_q  <= nxt_free_d;
    nxt_len_q   <= nxt_len_d;
    k_q         <= k_d;
    pos_q       <= pos_d;
    res_st_q    <= res_st_d;
    res_base_q  <= res_base_d;
    ost_q       <= ost_d;
    obase_q     <= obase_d;
  end

  assign out_valid_o = ov_q;
  assign status_o    = ost_q;
  assign base_o      = base64[19:0];

endmodule

/* dv/segment_fit_allocator_tb.sv */
// ----------------------------------------------------------------------------
// segment_fit_allocator_tb: self-checking bench for the segment fit allocator
// Drives create, delete and compact commands in random bursts against a
// region table model kept in the bench, and compares every result beat with
// the predicted status and base. Fit policy and memory size change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module segment_fit_allocator_tb import sfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREG = 64;
  localparam logic [2:0] CMD_NOP = 3'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] id;
    logic [20:0] size;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] base;
  } res_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = '0;
  logic [15:0] seg_id_i = '0;
  logic [20:0] req_size_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [19:0] base_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [20:0] cfg_data_i = '0;

  segment_fit_allocator dut (.*);

  always #2 clk_i = ~clk_i;

  // Model of the region table.
  logic [1:0]  pol;
  int unsigned mem_sz;
  bit          rfree [NREG];
  logic [15:0] rown  [NREG];
  int unsigned rbase [NREG];
  int unsigned rlen  [NREG];
  int unsigned rcnt;

  cmd_beat_t pending_cmds[$];
  res_beat_t expected_results[$];
  int        errors = 0;
  bit        hold_off = 1'b0;

  function automatic void table_clear();
    for (int k = 0; k < NREG; k++) begin
      rfree[k] = 0; rown[k] = '0; rbase[k] = 0; rlen[k] = 0;
    end
    rfree[0] = 1; rlen[0] = mem_sz; rcnt = 1;
  endfunction

  function automatic void drop_region(int unsigned i);
    for (int unsigned k = i; k + 1 < rcnt; k++) begin
      rfree[k] = rfree[k+1]; rown[k] = rown[k+1];
      rbase[k] = rbase[k+1]; rlen[k] = rlen[k+1];
    end
    rcnt--;
  endfunction

  function automatic res_beat_t run_allocator(cmd_beat_t c);
    res_beat_t r;
    int unsigned i, pick, w, pos;
    bit found;
    longint unsigned total;
    r = '0;
    pick = 0; found = 0; total = 0; w = 0; pos = 0;
    case (c.cmd)
      CMD_CREATE: begin
        if (c.size != 0) begin
          for (i = 0; i < rcnt; i++) begin
            if (!rfree[i]) continue;
            total += rlen[i];
            if (rlen[i] < c.size) continue;
            if (!found) begin
              pick = i; found = 1;
              if (pol != POL_BEST && pol != POL_WORST) break;
            end else if (pol == POL_BEST && rlen[i] < rlen[pick]) begin
              pick = i;
            end else if (pol == POL_WORST && rlen[i] > rlen[pick]) begin
              pick = i;
            end
          end
          if (!found) begin
            for (; i < rcnt; i++) if (rfree[i]) total += rlen[i];
            r.status = (total >= c.size) ? ST_COMPACT : ST_NOSPACE;
          end else if (rlen[pick] == c.size) begin
            rfree[pick] = 0; rown[pick] = c.id; r.base = 20'(rbase[pick]);
          end else if (rcnt >= NREG) begin
            r.status = ST_FULL;
          end else begin
            for (int k = int'(rcnt); k > int'(pick); k--) begin
              rfree[k] = rfree[k-1]; rown[k] = rown[k-1];
              rbase[k] = rbase[k-1]; rlen[k] = rlen[k-1];
            end
            rcnt++;
            rfree[pick] = 0; rown[pick] = c.id; rlen[pick] = c.size;
            rbase[pick+1] += c.size; rlen[pick+1] -= c.size;
            r.base = 20'(rbase[pick]);
          end
        end
      end
      CMD_DELETE: begin
        for (i = 0; i < rcnt; i++) if (!rfree[i] && rown[i] == c.id) break;
        if (i >= rcnt) begin
          r.status = ST_NOTFOUND;
        end else begin
          rfree[i] = 1; rown[i] = '0;
          if (i + 1 < rcnt && rfree[i+1]) begin
            rlen[i] += rlen[i+1]; drop_region(i + 1);
          end
          if (i > 0 && rfree[i-1]) begin
            rlen[i-1] += rlen[i]; drop_region(i);
          end
        end
      end
      CMD_COMPACT: begin
        for (i = 0; i < rcnt; i++) begin
          if (rfree[i]) continue;
          rfree[w] = 0; rown[w] = rown[i]; rlen[w] = rlen[i];
          rbase[w] = pos; pos += rlen[i]; w++;
        end
        if (pos < mem_sz && w < NREG) begin
          rfree[w] = 1; rown[w] = '0; rbase[w] = pos; rlen[w] = mem_sz - pos; w++;
        end
        rcnt = w;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: bursts of beats with random gaps; the payload holds while stalled.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(run_allocator({cmd_i, seg_id_i, req_size_i}));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_beat_t c;
          c = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= c.cmd; seg_id_i <= c.id; req_size_i <= c.size;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off when asked.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_off) out_stall_i <= 1'b1;
    else case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat status=%0d base=%0d", status_o, base_o);
        errors++;
      end else begin
        res_beat_t e;
        e = expected_results.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          errors++;
        end
        if (base_o !== e.base) begin
          $error("base expected %0d actual %0d", e.base, base_o);
          errors++;
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Apply a register write; the model applies the same clipping.
  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POLICY) pol = val[1:0];
    else if (idx == CFG_MEMSIZE) begin
      mem_sz = (val == 0) ? 1 : ((val > 21'h100000) ? 32'h100000 : val);
      table_clear();
    end
  endtask

  function automatic void push_cmd(logic [1:0] c, logic [15:0] id, logic [20:0] sz);
    pending_cmds.push_back('{cmd: c, id: id, size: sz});
  endfunction

  // Mostly well-formed allocate/free traffic over a small id pool.
  function automatic void push_random(int n, int unsigned msz);
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50)
        push_cmd(CMD_CREATE, 16'($urandom_range(0, 40)),
                 ($urandom_range(0, 9) == 0) ? 21'($urandom) :
                 21'($urandom_range(1, (msz / 12) + 1)));
      else if (r < 85)
        push_cmd(CMD_DELETE, ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                 16'($urandom_range(0, 40)), 21'($urandom));
      else if (r < 95)
        push_cmd(CMD_COMPACT, 16'($urandom), 21'($urandom));
      else
        push_cmd(CMD_NOP[1:0], 16'($urandom), 21'($urandom));
    end
  endfunction

  initial begin
    pol = '0;
    mem_sz = MEM_SIZE_RESET;
    table_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: zero size, exact fit, oversize, fragmentation, unknown id.
    push_cmd(CMD_CREATE, 16'hFFFF, 21'd0);
    push_cmd(CMD_CREATE, 16'd1, 21'd1024);
    push_cmd(CMD_CREATE, 16'd2, 21'd1024);
    push_cmd(CMD_CREATE, 16'd1, 21'd512);
    push_cmd(CMD_CREATE, 16'd3, 21'd1536);
    push_cmd(CMD_DELETE, 16'd1, 21'd0);
    push_cmd(CMD_DELETE, 16'd3, 21'd0);
    push_cmd(CMD_CREATE, 16'd4, 21'd2048);
    push_cmd(CMD_CREATE, 16'd5, 21'h1FFFFF);
    push_cmd(CMD_DELETE, 16'hABCD, 21'h1FFFFF);
    push_cmd(CMD_NOP[1:0], 16'hFFFF, 21'h1FFFFF);
    push_cmd(CMD_COMPACT, 16'd0, 21'd0);
    push_cmd(CMD_CREATE, 16'd4, 21'd2048);
    push_cmd(CMD_DELETE, 16'd1, 21'd0);
    push_cmd(CMD_DELETE, 16'd1, 21'd0);
    push_cmd(CMD_DELETE, 16'd2, 21'd0);
    push_cmd(CMD_DELETE, 16'd4, 21'd0);
    wait_idle();

    // Policy and size phases, extremes included.
    write_reg(CFG_POLICY, 21'd1);
    write_reg(CFG_MEMSIZE, 21'd0);
    push_cmd(CMD_CREATE, 16'd7, 21'd1);
    push_cmd(CMD_CREATE, 16'd8, 21'd1);
    push_cmd(CMD_DELETE, 16'd7, 21'd0);
    wait_idle();
    write_reg(CFG_MEMSIZE, 21'h1FFFFF);
    push_cmd(CMD_CREATE, 16'd9, 21'h100000);
    push_cmd(CMD_DELETE, 16'd9, 21'd0);
    push_random(150, 21'h100000);
    wait_idle();

    // Table-full pressure: many tiny segments and a long receiver hold-off.
    write_reg(CFG_POLICY, 21'd0);
    write_reg(CFG_MEMSIZE, 21'd200);
    for (int k = 0; k < 70; k++) push_cmd(CMD_CREATE, 16'(k), 21'd2);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b0;
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_POLICY, 21'(ph));
      write_reg(CFG_MEMSIZE, 21'($urandom_range(64, 8192)));
      push_random(160, mem_sz);
      wait_idle();
    end

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
